FILE: hdl/mke_pkg.sv
package mke_pkg;

	// Histogram counter width; every bin saturates at all ones
	localparam int COUNT_WIDTH = 32;
	localparam int DUR_W       = 16;
	localparam int PITCH_W     = 7;
	localparam int CLASS_W     = 4;
	localparam int NUM_CLASSES = 12;
	localparam int NUM_DEG     = 7;
	localparam int DEG_W       = 3;
	// Seven bins summed per score need three more bits
	localparam int SCORE_XTRA  = 3;
	localparam int SCORE_W     = COUNT_WIDTH + SCORE_XTRA;

	localparam logic [CLASS_W-1:0] LAST_ROOT    = CLASS_W'(NUM_CLASSES - 1);
	localparam logic [DEG_W-1:0]   LAST_DEG     = DEG_W'(NUM_DEG - 1);
	localparam logic [CLASS_W-1:0] SIXTH_OFFSET = CLASS_W'(9);

	// Major-scale degree offsets from the root
	localparam logic [CLASS_W-1:0] DEG_OFS [NUM_DEG] = '{
		4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11
	};

	// Roots kept outright when ranked best: C, E and G
	localparam logic [NUM_CLASSES-1:0] KEEP_ROOT = 12'b0000_1001_0001;

	typedef struct packed {
		logic               kind;
		logic [PITCH_W-1:0] note_pitch;
		logic [DUR_W-1:0]   note_duration;
	} mke_in_t;

	typedef struct packed {
		logic [CLASS_W-1:0] key_root;
		logic               is_major;
	} mke_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCORE,
		ST_RANK,
		ST_PICK,
		ST_TONIC,
		ST_EMIT
	} mke_state_t;

	typedef enum logic [1:0] {
		RD_NOTE,
		RD_SCORE,
		RD_TONIC,
		RD_SIXTH
	} mke_rd_sel_t;

	typedef struct packed {
		mke_rd_sel_t        rd_sel;
		logic [CLASS_W-1:0] root;
		logic [DEG_W-1:0]   deg;
		logic               note_add;
		logic               score_step;
		logic               acc_first;
		logic               acc_last;
		logic               pick;
		logic               tonic_load;
		logic               emit;
	} mke_cmd_t;

	// Fold a value below 24 into 0..11
	function automatic logic [CLASS_W-1:0] wrap12(input logic [CLASS_W:0] v);
		logic [CLASS_W:0] r;
		r = (v >= (CLASS_W + 1)'(NUM_CLASSES)) ? v - (CLASS_W + 1)'(NUM_CLASSES) : v;
		return r[CLASS_W-1:0];
	endfunction

	// Pitch class of a 7-bit note: quotient by reciprocal 43/512, exact below 128
	function automatic logic [CLASS_W-1:0] pitch_class(input logic [PITCH_W-1:0] p);
		logic [12:0]        prod;
		logic [CLASS_W-1:0] q;
		logic [PITCH_W-1:0] r;
		prod = 13'(p) * 13'd43;
		q    = prod[12:9];
		r    = p - PITCH_W'(q) * PITCH_W'(NUM_CLASSES);
		return r[CLASS_W-1:0];
	endfunction

endpackage

FILE: hdl/musical_key_estimator.sv
// Musical key estimator. A note beat (kind 0) adds its duration to the bin of
// its pitch class and keeps busy low, so notes may be started on every cycle
// while busy is low. A finish beat (kind 1) raises busy while the block scans
// the 12 roots times 7 scale degrees, one bin read per cycle through the single
// histogram read port, then finishes ranking, chooses the root and reads the
// tonic and sixth weights. done pulses for one cycle with key_root and is_major
// on result; the receiver must take it then, as it is not held. The histogram
// is cleared as the result is issued. Bins saturate at all ones.
module musical_key_estimator import mke_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  mke_in_t  item,
	output logic     busy,
	output logic     done,
	output mke_out_t result
);

	mke_cmd_t cmd;

	mke_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.busy   (busy),
		.cmd    (cmd)
	);

	mke_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.done   (done),
		.result (result)
	);

endmodule

FILE: hdl/mke_ctrl.sv
module mke_ctrl import mke_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     kind,
	output logic     busy,
	output mke_cmd_t cmd
);

	mke_state_t         state_q, state_d;
	logic [CLASS_W-1:0] root_q;
	logic [DEG_W-1:0]   deg_q;
	logic               scan_end;

	assign scan_end = (deg_q == LAST_DEG) && (root_q == LAST_ROOT);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start && kind) state_d = ST_SCORE;
			ST_SCORE: if (scan_end) state_d = ST_RANK;
			ST_RANK:  state_d = ST_PICK;
			ST_PICK:  state_d = ST_TONIC;
			ST_TONIC: state_d = ST_EMIT;
			ST_EMIT:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd            = '0;
		cmd.rd_sel     = RD_NOTE;
		cmd.root       = root_q;
		cmd.deg        = deg_q;
		unique case (state_q)
			ST_IDLE:  cmd.note_add = start && !kind;
			ST_SCORE: begin
				cmd.rd_sel     = RD_SCORE;
				cmd.score_step = 1'b1;
				cmd.acc_first  = (deg_q == '0);
				cmd.acc_last   = (deg_q == LAST_DEG);
			end
			ST_RANK:  ;
			ST_PICK:  cmd.pick = 1'b1;
			ST_TONIC: begin
				cmd.rd_sel     = RD_TONIC;
				cmd.tonic_load = 1'b1;
			end
			ST_EMIT:  begin
				cmd.rd_sel = RD_SIXTH;
				cmd.emit   = 1'b1;
			end
			default:  ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Walk roots, and the seven scale degrees within each root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			deg_q  <= '0;
		end else if (state_q == ST_IDLE) begin
			root_q <= '0;
			deg_q  <= '0;
		end else if (state_q == ST_SCORE) begin
			if (deg_q == LAST_DEG) begin
				deg_q  <= '0;
				root_q <= root_q + CLASS_W'(1);
			end else begin
				deg_q <= deg_q + DEG_W'(1);
			end
		end
	end

	// Ranking only ever follows the full score scan
	a_rank_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RANK |-> $past(state_q) == ST_SCORE)
		else $error("rank step not preceded by score scan");

	// The scan stops at the last root
	a_scan_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCORE |-> root_q <= LAST_ROOT && deg_q <= LAST_DEG)
		else $error("score scan index out of range");

endmodule

FILE: hdl/mke_dp.sv
module mke_dp import mke_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mke_cmd_t cmd,
	input  mke_in_t  item,
	output logic     done,
	output mke_out_t result
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] bin_q [NUM_CLASSES];
	logic [CLASS_W-1:0]     note_pc;
	logic [CLASS_W-1:0]     rd_addr;
	logic [COUNT_WIDTH-1:0] rd_data;
	logic [COUNT_WIDTH:0]   note_sum;
	logic [SCORE_W-1:0]     rd_ext;
	logic [SCORE_W-1:0]     acc_q;
	logic [SCORE_W-1:0]     score_s1;
	logic [CLASS_W-1:0]     score_root_s1;
	logic                   rank_en_s1;
	logic [SCORE_W-1:0]     best_score_q, sec_score_q;
	logic [CLASS_W-1:0]     best_q, sec_q, root_q;
	logic                   sec_vld_q;
	logic [COUNT_WIDTH-1:0] tonic_q;
	logic                   done_q;
	mke_out_t               result_q;
	logic                   bins_empty;

	assign note_pc = pitch_class(item.note_pitch);

	// Pick the single bin read address
	always_comb begin
		unique case (cmd.rd_sel)
			RD_NOTE:  rd_addr = note_pc;
			RD_SCORE: rd_addr = wrap12({1'b0, cmd.root} + {1'b0, DEG_OFS[cmd.deg]});
			RD_TONIC: rd_addr = root_q;
			RD_SIXTH: rd_addr = wrap12({1'b0, root_q} + {1'b0, SIXTH_OFFSET});
			default:  rd_addr = '0;
		endcase
	end

	assign rd_data  = bin_q[rd_addr];
	assign note_sum = {1'b0, rd_data} + (COUNT_WIDTH + 1)'(item.note_duration);
	assign rd_ext   = {{SCORE_XTRA{1'b0}}, rd_data};

	// Add note beats into the histogram, clear it once a key is reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) bin_q[i] <= '0;
		end else if (cmd.emit) begin
			for (int i = 0; i < NUM_CLASSES; i++) bin_q[i] <= '0;
		end else if (cmd.note_add) begin
			bin_q[note_pc] <= note_sum[COUNT_WIDTH] ? COUNT_MAX : note_sum[COUNT_WIDTH-1:0];
		end
	end

	// Accumulate one scale degree per cycle; post the finished score
	always_ff @(posedge clk) begin
		if (cmd.score_step) begin
			acc_q <= cmd.acc_first ? rd_ext : acc_q + rd_ext;
		end
		if (cmd.acc_last) begin
			score_s1      <= acc_q + rd_ext;
			score_root_s1 <= cmd.root;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_en_s1 <= 1'b0;
		end else begin
			rank_en_s1 <= cmd.acc_last;
		end
	end

	// Keep the top two roots; a later root must beat strictly to move up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_vld_q <= 1'b0;
		end else if (rank_en_s1) begin
			if (score_root_s1 == '0) begin
				sec_vld_q <= 1'b0;
			end else begin
				sec_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rank_en_s1) begin
			priority if (score_root_s1 == '0) begin
				best_q       <= score_root_s1;
				best_score_q <= score_s1;
			end else if (score_s1 > best_score_q) begin
				sec_q        <= best_q;
				sec_score_q  <= best_score_q;
				best_q       <= score_root_s1;
				best_score_q <= score_s1;
			end else if (!sec_vld_q || score_s1 > sec_score_q) begin
				sec_q       <= score_root_s1;
				sec_score_q <= score_s1;
			end
		end
	end

	// Choose the root, then fetch tonic and sixth weights
	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			if (KEEP_ROOT[best_q]) begin
				root_q <= best_q;
			end else if (sec_score_q == best_score_q) begin
				root_q <= sec_q;
			end else begin
				root_q <= best_q;
			end
		end
		if (cmd.tonic_load) begin
			tonic_q <= rd_data;
		end
		if (cmd.emit) begin
			result_q.key_root <= root_q;
			result_q.is_major <= (tonic_q > rd_data);
		end
	end

	// Strobe the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	always_comb begin
		bins_empty = 1'b1;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			if (bin_q[i] != '0) bins_empty = 1'b0;
		end
	end

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> result_q.key_root <= LAST_ROOT)
		else $error("key root out of range");

	a_cleared_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> bins_empty)
		else $error("histogram not cleared with result");

	a_note_not_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.score_step |-> !cmd.note_add && !done_q)
		else $error("note beat or result during score scan");

endmodule
